// ===== hw/rtl/sorted_insert_priority_queue_macros.svh =====
// Assertion helpers used by the queue RTL.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond implies prop in the following cycle.
`define SPQ_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] item_key;
    logic [PAY_W-1:0] item_payload;
  } in_t;

  typedef struct packed {
    logic               out_valid;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    status_e            status;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

endpackage

// ===== hw/rtl/spq_store.sv =====
`timescale 1ns / 1ps

module spq_store import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sorted_insert_priority_queue.sv =====
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries kept in key order in a circular
// buffer held in a single-port-write, single-port-read memory. A transaction
// with mode insert places its key and payload behind every stored entry with
// a key less than or equal to its own; mode remove returns the head entry,
// which has the smallest key. Each transaction yields exactly one result with
// status and entry count. One sequencer with one slot adder walks the buffer
// from the tail toward the head, one entry per read-compare pair; an insert
// shifts each examined entry with a larger key up one slot, then writes its
// own entry; a remove reads the head, then takes it; a full or empty error
// goes straight to the result. The memory's read port is registered.
// in_ready_o is low while a transaction is in progress and while its result
// waits for the output register to free up.

`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_S = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
  localparam logic [IDX_W-1:0] ONE_I   = IDX_W'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_HEAD = 3'd4;
  localparam logic [2:0] S_TAKE = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic [COUNT_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  entry_t           item_q, item_d;
  out_t             pend_q, pend_d;
  out_t             out_q;
  logic             out_vld_q;
  logic             out_free;

  logic [IDX_W-1:0] offset;
  logic [IDX_W:0]   slot_sum;
  logic [IDX_W:0]   slot_wrap;
  logic [IDX_W-1:0] slot;

  logic             we;
  entry_t           wdata;
  logic             re;
  entry_t           rdata;

  assign out_free = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // shared slot adder: (head + offset) mod DEPTH
  assign slot_sum  = {1'b0, head_q} + {1'b0, offset};
  assign slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
  assign slot      = slot_wrap[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    item_d  = item_q;
    pend_d  = pend_q;
    offset  = pos_q;
    we      = 1'b0;
    wdata   = item_q;
    re      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d.key     = in_data_i.item_key;
          item_d.payload = in_data_i.item_payload;
          pend_d         = '0;
          pend_d.entry_count = count_out(cnt_q);
          if (in_data_i.mode == MODE_INSERT) begin
            if (cnt_q == DEPTH_C) begin
              pend_d.status = ST_FULL;
              state_d       = S_DONE;
            end else if (cnt_q == '0) begin
              head_d  = '0;
              pos_d   = '0;
              state_d = S_WR;
            end else begin
              pos_d   = cnt_q[IDX_W-1:0];
              state_d = S_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              pend_d.status = ST_EMPTY;
              state_d       = S_DONE;
            end else begin
              state_d = S_HEAD;
            end
          end
        end
      end
      S_RD: begin
        offset  = pos_q - ONE_I;
        re      = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        offset = pos_q;
        if (rdata.key > item_q.key) begin
          we    = 1'b1;
          wdata = rdata;
          pos_d = pos_q - ONE_I;
          state_d = (pos_q == ONE_I) ? S_WR : S_RD;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        offset  = pos_q;
        we      = 1'b1;
        wdata   = item_q;
        cnt_d   = cnt_q + ONE_C;
        pend_d  = '0;
        pend_d.status      = ST_OK;
        pend_d.entry_count = count_out(cnt_q + ONE_C);
        state_d = S_DONE;
      end
      S_HEAD: begin
        offset  = '0;
        re      = 1'b1;
        state_d = S_TAKE;
      end
      S_TAKE: begin
        offset = ONE_I;
        cnt_d  = cnt_q - ONE_C;
        head_d = (cnt_q == ONE_C) ? '0 : slot;
        pend_d.out_valid   = 1'b1;
        pend_d.out_key     = rdata.key;
        pend_d.out_payload = rdata.payload;
        pend_d.status      = ST_OK;
        pend_d.entry_count = count_out(cnt_q - ONE_C);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  spq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (slot),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pend_q <= pend_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `SPQ_ASSERT(a_count_bound, cnt_q <= DEPTH_C, "entry count exceeds depth")
  `SPQ_ASSERT(a_read_pos, (state_q != S_RD) || (pos_q != '0), "tail walk read below head")
  `SPQ_ASSERT_NEXT(a_insert_count, state_q == S_WR, cnt_q == $past(cnt_q) + ONE_C, "insert count")
  `SPQ_ASSERT_NEXT(a_take_count, state_q == S_TAKE, cnt_q == $past(cnt_q) - ONE_C, "remove count")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;

  class queue_tracker;
    entry_t      slots[DEPTH];
    int unsigned head = 0;
    int unsigned stored = 0;
    int unsigned errors = 0;
    out_t        predicted_results[$];

    function int unsigned slot(int unsigned pos);
      return (head + pos) % DEPTH;
    endfunction

    function void apply_transaction(in_t tr);
      out_t        res;
      int unsigned pos;
      int unsigned k;
      res = '0;
      res.status = ST_OK;
      if (tr.mode == MODE_INSERT) begin
        if (stored >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (stored == 0) head = 0;
          pos = stored;
          while (pos > 0 && slots[slot(pos - 1)].key > tr.item_key) pos--;
          for (k = stored; k > pos; k--) slots[slot(k)] = slots[slot(k - 1)];
          slots[slot(pos)].key = tr.item_key;
          slots[slot(pos)].payload = tr.item_payload;
          stored++;
        end
      end else if (stored == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_valid = 1'b1;
        res.out_key = slots[head].key;
        res.out_payload = slots[head].payload;
        stored--;
        head = (stored == 0) ? 0 : slot(1);
      end
      res.entry_count = COUNT_W'(stored);
      predicted_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      compare_field("out_valid", want.out_valid, got.out_valid);
      compare_field("out_key", want.out_key, got.out_key);
      compare_field("out_payload", want.out_payload, got.out_payload);
      compare_field("status", want.status, got.status);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  queue_tracker tracker;
  int unsigned  src_idle = 0;
  int unsigned  sink_stall = 0;
  bit           hold_req = 1'b0;
  int unsigned  quiet_cycles = 0;

  sorted_insert_priority_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic in_t make_item(logic mode, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    in_t tr;
    tr.mode = mode;
    tr.item_key = key;
    tr.item_payload = pay;
    return tr;
  endfunction

  function automatic in_t random_transaction(int unsigned insert_pct);
    logic [KEY_W-1:0] key;
    case ($urandom_range(3))
      0: key = KEY_W'($urandom);
      1: key = KEY_W'($urandom_range(7));
      2: key = 16'hFFFF - KEY_W'($urandom_range(3));
      default: key = KEY_W'($urandom_range(255)) << 8;
    endcase
    return make_item(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                     key, PAY_W'($urandom));
  endfunction

  task automatic send_transaction(in_t tr);
    in_valid_i <= 1'b1;
    in_data_i <= tr;
    do @(posedge clk_i); while (!in_ready_o);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.apply_transaction(in_data_i);
      if (out_valid_o && out_ready_i) tracker.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned i;
    int unsigned burst_left;
    int unsigned insert_pct;
    int unsigned idle_table[4];
    int unsigned stall_table[4];
    idle_table = '{0, 85, 0, 27};
    stall_table = '{0, 0, 85, 27};
    burst_left = 0;
    insert_pct = 50;
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_transaction(make_item(MODE_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
    send_transaction(make_item(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
    send_transaction(make_item(MODE_INSERT, 16'h0000, 32'h0000_0000));
    send_transaction(make_item(MODE_INSERT, 16'h8000, 32'hA5A5_A5A5));
    send_transaction(make_item(MODE_INSERT, 16'h8000, 32'h5A5A_5A5A));
    send_transaction(make_item(MODE_REMOVE, 16'h0000, 32'h0000_0000));
    for (i = 0; i < 13; i++) begin
      send_transaction(make_item(MODE_INSERT,
                                 (i % 4 == 0) ? 16'hFFFF :
                                 (i % 4 == 1) ? 16'h8000 : 16'h7F00 - KEY_W'(i),
                                 32'h100 + i));
    end
    send_transaction(make_item(MODE_INSERT, 16'h1234, 32'hDEAD_BEEF));
    send_transaction(make_item(MODE_REMOVE, 16'h0000, 32'h0000_0000));

    for (phase = 0; phase < 4; phase++) begin
      src_idle = idle_table[phase];
      sink_stall = stall_table[phase];
      if (phase == 0) hold_req = 1'b1;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(2))
            0: insert_pct = 20;
            1: insert_pct = 50;
            default: insert_pct = 80;
          endcase
        end
        burst_left--;
        send_transaction(random_transaction(insert_pct));
      end
    end

    in_valid_i <= 1'b0;
    while (tracker.predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.predicted_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_store.sv
hw/rtl/sorted_insert_priority_queue.sv
bench/testbench.sv
